FILE: sv/trbs_pkg.sv
// ----------------------------------------------------------------------------
// trbs_pkg
// Shared types and constants for the timed bidirectional relay sequencer.
// ----------------------------------------------------------------------------
package trbs_pkg;

  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [15:0] EnterDelayReset   = 16'd40000;
  localparam logic [15:0] ExitDelayReset    = 16'd15000;
  localparam logic [15:0] LongPressReset    = 16'd1000;
  localparam logic [15:0] PanicTimeoutReset = 16'd1500;
  localparam logic [7:0]  DebounceReset     = 8'd10;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_ENTER_DELAY   = 3'd0,
    CFG_EXIT_DELAY    = 3'd1,
    CFG_LONG_PRESS    = 3'd2,
    CFG_PANIC_TIMEOUT = 3'd3,
    CFG_DEBOUNCE      = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    MODE_MANUAL   = 3'd0,
    MODE_R_ENTER  = 3'd1,
    MODE_R_UPDATE = 3'd2,
    MODE_R_EXIT   = 3'd3,
    MODE_L_ENTER  = 3'd4,
    MODE_L_UPDATE = 3'd5,
    MODE_L_EXIT   = 3'd6,
    MODE_PANIC    = 3'd7
  } mode_t;

  typedef struct packed {
    logic panic_level;
    logic right_level;
    logic left_level;
  } in_item_t;

  typedef struct packed {
    logic       relay_forward;
    logic       relay_reverse;
    logic [2:0] mode_code;
    logic       auto_flag;
  } out_item_t;

  typedef struct packed {
    logic [15:0] enter_delay_ms;
    logic [15:0] exit_delay_ms;
    logic [15:0] long_press_ms;
    logic [15:0] panic_timeout_ms;
    logic [7:0]  debounce_ms;
  } cfg_t;

  // Per-button events for one tick.
  typedef struct packed {
    logic pressed;
    logic released;
    logic long_press;
  } btn_evt_t;

endpackage

FILE: sv/trbs_button.sv
// ----------------------------------------------------------------------------
// trbs_button
// Debounce and hold timer for one active-low button.
// ----------------------------------------------------------------------------
module trbs_button
  import trbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        level,
  input  logic [7:0]  debounce_ms,
  input  logic [15:0] long_press_ms,
  output btn_evt_t    evt
);

  logic        down;
  logic        down_next;
  logic [7:0]  count;
  logic [7:0]  count_next;
  logic [15:0] hold;
  logic [15:0] hold_next;
  logic [7:0]  need;
  logic [7:0]  count_inc;
  logic [15:0] hold_inc;
  logic        low;

  assign low       = ~level;
  assign need      = (debounce_ms == 8'd0) ? 8'd1 : debounce_ms;
  assign count_inc = (count == 8'hFF) ? count : count + 8'd1;
  assign hold_inc  = (down && hold != 16'hFFFF) ? hold + 16'd1 : hold;

  always_comb begin
    down_next        = down;
    count_next       = count;
    hold_next        = hold_inc;
    evt.pressed      = 1'b0;
    evt.released     = 1'b0;
    // A press always restarts the hold count, so only a button that was
    // already down can show a long hold on this tick.
    evt.long_press   = down && (hold_inc > long_press_ms);
    if (!down) begin
      if (low) begin
        if (count_inc >= need) begin
          down_next   = 1'b1;
          count_next  = 8'd0;
          hold_next   = 16'd0;
          evt.pressed = 1'b1;
        end else begin
          count_next = count_inc;
        end
      end else begin
        count_next = 8'd0;
      end
    end else if (!low) begin
      down_next    = 1'b0;
      count_next   = 8'd0;
      evt.released = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down  <= 1'b0;
      count <= 8'd0;
      hold  <= 16'd0;
    end else if (tick) begin
      down  <= down_next;
      count <= count_next;
      hold  <= hold_next;
    end
  end

endmodule

FILE: sv/trbs_seq.sv
// ----------------------------------------------------------------------------
// trbs_seq
// Eight-state relay sequencer with its elapsed-time counter.
// ----------------------------------------------------------------------------
module trbs_seq
  import trbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      tick,
  input  cfg_t      cfg,
  input  btn_evt_t  panic_evt,
  input  btn_evt_t  right_evt,
  input  btn_evt_t  left_evt,
  output out_item_t result
);

  mode_t       mode;
  mode_t       mode_next;
  logic [15:0] elapsed;
  logic [15:0] elapsed_next;
  logic        cycling;
  logic        cycling_next;
  logic [1:0]  relay;
  logic [1:0]  relay_next;
  logic [15:0] elapsed_inc;

  assign elapsed_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;

  always_comb begin
    mode_next    = mode;
    elapsed_next = elapsed_inc;
    cycling_next = cycling;
    relay_next   = relay;
    if (mode != MODE_PANIC && panic_evt.pressed) begin
      // Forced panic keeps the relays and the running time for this tick.
      mode_next = MODE_PANIC;
    end else begin
      unique case (mode)
        MODE_MANUAL: begin
          if (right_evt.released) begin
            mode_next    = MODE_R_ENTER;
            elapsed_next = 16'd0;
            cycling_next = right_evt.long_press;
          end else if (left_evt.released) begin
            mode_next    = MODE_L_ENTER;
            elapsed_next = 16'd0;
            cycling_next = left_evt.long_press;
          end
        end
        MODE_R_ENTER, MODE_L_ENTER: begin
          if (!(cycling && elapsed_inc < cfg.enter_delay_ms)) begin
            elapsed_next = 16'd0;
            if (mode == MODE_R_ENTER) begin
              relay_next = 2'b01;
              mode_next  = MODE_R_UPDATE;
            end else begin
              relay_next = 2'b10;
              mode_next  = MODE_L_UPDATE;
            end
          end
        end
        MODE_R_UPDATE, MODE_L_UPDATE: begin
          if (elapsed_inc > cfg.panic_timeout_ms) begin
            mode_next    = MODE_PANIC;
            elapsed_next = 16'd0;
          end else if (mode == MODE_R_UPDATE && right_evt.released) begin
            mode_next    = MODE_R_EXIT;
            elapsed_next = 16'd0;
          end else if (mode == MODE_L_UPDATE && left_evt.released) begin
            mode_next    = MODE_L_EXIT;
            elapsed_next = 16'd0;
          end
        end
        MODE_R_EXIT, MODE_L_EXIT: begin
          if (!(cycling && elapsed_inc < cfg.exit_delay_ms)) begin
            relay_next   = 2'b00;
            elapsed_next = 16'd0;
            if (!cycling) begin
              mode_next = MODE_MANUAL;
            end else if (mode == MODE_R_EXIT) begin
              mode_next = MODE_L_ENTER;
            end else begin
              mode_next = MODE_R_ENTER;
            end
          end
        end
        MODE_PANIC: begin
          relay_next = 2'b00;
          if (panic_evt.pressed) begin
            mode_next    = MODE_MANUAL;
            elapsed_next = 16'd0;
          end
        end
        default: begin
          mode_next = MODE_MANUAL;
        end
      endcase
    end
  end

  // The result shows the state after this tick.
  always_comb begin
    result.relay_forward = relay_next[0];
    result.relay_reverse = relay_next[1];
    result.mode_code     = mode_next;
    result.auto_flag     = cycling_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_MANUAL;
      elapsed <= 16'd0;
      cycling <= 1'b0;
      relay   <= 2'b00;
    end else if (tick) begin
      mode    <= mode_next;
      elapsed <= elapsed_next;
      cycling <= cycling_next;
      relay   <= relay_next;
    end
  end

endmodule

FILE: sv/timed_bidirectional_relay_sequencer.sv
// ----------------------------------------------------------------------------
// timed_bidirectional_relay_sequencer
// Top level: configuration registers, button debouncers, sequencer and a
// two-entry result buffer.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying three active-low button
// levels. The block takes one beat per clock while in_stall is low and
// registers each result beat; the whole tick update is combinational from
// the stored button and sequencer state to the result register. A two-entry
// result buffer lets one more tick enter while a result is stalled, and
// in_stall rises only when both entries are full. Configuration writes are
// accepted in every cycle and take effect from the next tick.
module timed_bidirectional_relay_sequencer
  import trbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]              cfg_data
);

  cfg_t      cfg;
  btn_evt_t  panic_evt;
  btn_evt_t  right_evt;
  btn_evt_t  left_evt;
  out_item_t result;
  out_item_t skid_data;
  logic      skid_valid;
  logic      tick;
  logic      take_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign tick      = in_valid && !skid_valid;
  assign take_out  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_delay_ms   <= EnterDelayReset;
      cfg.exit_delay_ms    <= ExitDelayReset;
      cfg.long_press_ms    <= LongPressReset;
      cfg.panic_timeout_ms <= PanicTimeoutReset;
      cfg.debounce_ms      <= DebounceReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENTER_DELAY:   cfg.enter_delay_ms   <= cfg_data;
        CFG_EXIT_DELAY:    cfg.exit_delay_ms    <= cfg_data;
        CFG_LONG_PRESS:    cfg.long_press_ms    <= cfg_data;
        CFG_PANIC_TIMEOUT: cfg.panic_timeout_ms <= cfg_data;
        CFG_DEBOUNCE:      cfg.debounce_ms      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  trbs_button u_panic (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .level         (in_data.panic_level),
    .debounce_ms   (cfg.debounce_ms),
    .long_press_ms (cfg.long_press_ms),
    .evt           (panic_evt)
  );

  trbs_button u_right (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .level         (in_data.right_level),
    .debounce_ms   (cfg.debounce_ms),
    .long_press_ms (cfg.long_press_ms),
    .evt           (right_evt)
  );

  trbs_button u_left (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .level         (in_data.left_level),
    .debounce_ms   (cfg.debounce_ms),
    .long_press_ms (cfg.long_press_ms),
    .evt           (left_evt)
  );

  trbs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .cfg       (cfg),
    .panic_evt (panic_evt),
    .right_evt (right_evt),
    .left_evt  (left_evt),
    .result    (result)
  );

  // The skid entry only ever holds the younger of two results, so draining
  // it into the output register keeps the beats in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take_out) begin
        skid_valid <= 1'b0;
      end
    end else if (tick) begin
      if (!out_valid || take_out) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take_out) begin
        out_data <= skid_data;
      end
    end else if (tick) begin
      if (!out_valid || take_out) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

endmodule

FILE: sv/trbs_checker.sv
// ----------------------------------------------------------------------------
// trbs_checker
// Port-level checks for the relay sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module trbs_checker
  import trbs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // The two relays are never driven together.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.relay_forward && out_data.relay_reverse))
    else $error("both relays driven");

  // The forward relay runs only while updating or leaving right, or frozen in panic.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.relay_forward |->
      (out_data.mode_code == MODE_R_UPDATE || out_data.mode_code == MODE_R_EXIT ||
       out_data.mode_code == MODE_PANIC))
    else $error("forward relay on in an unexpected mode");

endmodule

bind timed_bidirectional_relay_sequencer trbs_checker u_trbs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives millisecond ticks of button levels into the relay sequencer and
// compares every result beat with a cycle-free model of the debouncers and
// the eight-state sequencer. A short stimulus list comes first, then phases
// of random button gestures under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import trbs_pkg::*;

  localparam int          IdleLimit    = 1000;
  localparam int          PhaseTicks   = 60;
  localparam int          NumPhases    = 6;
  localparam int          NumSteps     = 25;
  localparam int          MaxPrinted   = 40;
  localparam int          MaxBounce    = 8;
  localparam in_item_t    ALL_RELEASED = 3'b111;
  localparam logic [1:0]  RELAY_OFF    = 2'b00;
  localparam logic [1:0]  RELAY_FWD    = 2'b01;
  localparam logic [1:0]  RELAY_REV    = 2'b10;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = ALL_RELEASED;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = CFG_ENTER_DELAY;
  logic [15:0]              cfg_data = '0;

  // Model state, mirroring the block after reset.
  cfg_t        cfg_shadow = '{enter_delay_ms: EnterDelayReset, exit_delay_ms: ExitDelayReset,
                              long_press_ms: LongPressReset,
                              panic_timeout_ms: PanicTimeoutReset,
                              debounce_ms: DebounceReset};
  mode_t       seq_mode = MODE_MANUAL;
  logic [15:0] seq_elapsed = '0;
  logic        seq_cycling = 1'b0;
  logic [2:0]  btn_down = '0;
  logic [7:0]  btn_count [3] = '{8'd0, 8'd0, 8'd0};
  logic [15:0] hold_ms [2] = '{16'd0, 16'd0};
  logic [1:0]  relay_state = RELAY_OFF;

  out_item_t   expected_ticks [$];
  dir_row_t    steps [NumSteps];
  int          fail_count = 0;
  int          result_count = 0;
  int          phase_ticks = 0;
  int          tx_burst = 0;
  int          rx_burst = 0;
  int          idle_cycles = 0;

  timed_bidirectional_relay_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void set_mode(mode_t m);
    seq_mode = m;
    seq_elapsed = '0;
  endfunction

  // One millisecond tick: debounce, then the sequencer, then the outputs.
  function automatic out_item_t tick_sequencer(in_item_t item);
    logic [2:0]  low;
    logic [2:0]  pressed;
    logic [2:0]  released;
    logic [1:0]  long_hold;
    logic [7:0]  need;
    logic [15:0] elapsed;
    out_item_t   o;
    // Button 0 is panic, 1 is right, 2 is left.
    low = ~{item.left_level, item.right_level, item.panic_level};
    need = (cfg_shadow.debounce_ms == 8'd0) ? 8'd1 : cfg_shadow.debounce_ms;
    elapsed = (seq_elapsed != 16'hFFFF) ? seq_elapsed + 16'd1 : 16'hFFFF;
    pressed = '0;
    released = '0;
    for (int i = 0; i < 3; i++) begin
      if (i > 0) begin
        if (btn_down[i] && hold_ms[i-1] != 16'hFFFF) hold_ms[i-1]++;
      end
      if (!btn_down[i]) begin
        if (low[i]) begin
          if (btn_count[i] != 8'hFF) btn_count[i]++;
          if (btn_count[i] >= need) begin
            btn_down[i] = 1'b1;
            pressed[i] = 1'b1;
            btn_count[i] = '0;
            if (i > 0) hold_ms[i-1] = '0;
          end
        end else begin
          btn_count[i] = '0;
        end
      end else if (!low[i]) begin
        btn_down[i] = 1'b0;
        released[i] = 1'b1;
        btn_count[i] = '0;
      end
    end
    for (int i = 0; i < 2; i++)
      long_hold[i] = (released[i+1] || btn_down[i+1]) && hold_ms[i] > cfg_shadow.long_press_ms;

    seq_elapsed = elapsed;
    // A forced panic keeps the relays and the elapsed count for this tick.
    if (seq_mode != MODE_PANIC && pressed[0]) begin
      seq_mode = MODE_PANIC;
    end else begin
      case (seq_mode)
        MODE_MANUAL: begin
          if (released[1]) begin
            set_mode(MODE_R_ENTER);
            seq_cycling = long_hold[0];
          end else if (released[2]) begin
            set_mode(MODE_L_ENTER);
            seq_cycling = long_hold[1];
          end
        end
        MODE_R_ENTER, MODE_L_ENTER: begin
          if (!(seq_cycling && elapsed < cfg_shadow.enter_delay_ms)) begin
            relay_state = (seq_mode == MODE_R_ENTER) ? RELAY_FWD : RELAY_REV;
            set_mode(mode_t'(seq_mode + 3'd1));
          end
        end
        MODE_R_UPDATE, MODE_L_UPDATE: begin
          if (elapsed > cfg_shadow.panic_timeout_ms)
            set_mode(MODE_PANIC);
          else if (released[(seq_mode == MODE_R_UPDATE) ? 1 : 2])
            set_mode(mode_t'(seq_mode + 3'd1));
        end
        MODE_R_EXIT, MODE_L_EXIT: begin
          if (!(seq_cycling && elapsed < cfg_shadow.exit_delay_ms)) begin
            relay_state = RELAY_OFF;
            if (seq_cycling)
              set_mode((seq_mode == MODE_R_EXIT) ? MODE_L_ENTER : MODE_R_ENTER);
            else
              set_mode(MODE_MANUAL);
          end
        end
        default: begin
          relay_state = RELAY_OFF;
          if (pressed[0]) set_mode(MODE_MANUAL);
        end
      endcase
    end

    o.relay_forward = relay_state[0];
    o.relay_reverse = relay_state[1];
    o.mode_code = seq_mode;
    o.auto_flag = seq_cycling;
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= MaxPrinted) $display("mismatch on result %0d: %s", result_count, msg);
  endtask

  // Leaves cfg_valid high so that back-to-back writes never lower and raise it
  // in the same step.
  task automatic write_reg(cfg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(CFG_ENTER_DELAY, c.enter_delay_ms);
    write_reg(CFG_EXIT_DELAY, c.exit_delay_ms);
    write_reg(CFG_LONG_PRESS, c.long_press_ms);
    write_reg(CFG_PANIC_TIMEOUT, c.panic_timeout_ms);
    write_reg(CFG_DEBOUNCE, {8'd0, c.debounce_ms});
    cfg_valid <= 1'b0;
    cfg_shadow = c;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic send_tick(in_item_t item, bit typed = 1'b0, out_item_t want = '0);
    int        gap;
    out_item_t predicted;
    if (tx_burst > 0) tx_burst--;
    else if ($urandom_range(0, 15) == 0) tx_burst = $urandom_range(10, 40);
    gap = (tx_burst > 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    predicted = tick_sequencer(item);
    expected_ticks.push_back(typed ? want : predicted);
    phase_ticks++;
  endtask

  task automatic hold_level(in_item_t item, int n);
    repeat (n) send_tick(item);
  endtask

  // Mostly clean presses and releases, with panic presses, bounce and noise.
  task automatic play_gesture();
    int       need;
    int       span;
    in_item_t lv;
    need = (cfg_shadow.debounce_ms == 8'd0) ? 1 : int'(cfg_shadow.debounce_ms);
    span = (cfg_shadow.long_press_ms > 16'd28) ? 60 : 2 * int'(cfg_shadow.long_press_ms) + 4;
    lv = ALL_RELEASED;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if ($urandom_range(0, 1)) lv.right_level = 1'b0;
        else lv.left_level = 1'b0;
        hold_level(lv, need + $urandom_range(0, span));
        hold_level(ALL_RELEASED, $urandom_range(0, 12));
      end
      5: begin
        lv.right_level = 1'b0;
        lv.left_level = 1'b0;
        hold_level(lv, need + $urandom_range(0, span));
        hold_level(ALL_RELEASED, $urandom_range(0, 12));
      end
      6: begin
        lv.panic_level = 1'b0;
        hold_level(lv, need + $urandom_range(0, 3));
        hold_level(ALL_RELEASED, $urandom_range(1, 4));
      end
      7: begin
        repeat ($urandom_range(1, 4)) begin
          lv = in_item_t'(3'($urandom_range(0, 6)));
          hold_level(lv, $urandom_range(1, (need > MaxBounce) ? MaxBounce : need));
          hold_level(ALL_RELEASED, $urandom_range(1, 2));
        end
      end
      8: begin
        repeat ($urandom_range(1, 10)) send_tick(in_item_t'(3'($urandom_range(0, 7))));
      end
      default: hold_level(ALL_RELEASED, $urandom_range(0, 80));
    endcase
  endtask

  task automatic collect_results();
    int        hold;
    out_item_t want;
    forever begin
      if (rx_burst > 0) rx_burst--;
      else if ($urandom_range(0, 15) == 0) rx_burst = $urandom_range(10, 40);
      hold = (rx_burst > 0) ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      result_count++;
      if (expected_ticks.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = expected_ticks.pop_front();
        if (out_data.relay_forward !== want.relay_forward)
          report_mismatch($sformatf("relay_forward %b, expected %b",
                                    out_data.relay_forward, want.relay_forward));
        if (out_data.relay_reverse !== want.relay_reverse)
          report_mismatch($sformatf("relay_reverse %b, expected %b",
                                    out_data.relay_reverse, want.relay_reverse));
        if (out_data.mode_code !== want.mode_code)
          report_mismatch($sformatf("mode_code %0d, expected %0d",
                                    out_data.mode_code, want.mode_code));
        if (out_data.auto_flag !== want.auto_flag)
          report_mismatch($sformatf("auto_flag %b, expected %b",
                                    out_data.auto_flag, want.auto_flag));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    cfg_t c;
    // Zero debounce acts as one tick, so each row below is a whole press or
    // release. Long press means more than two ticks held.
    steps = '{
      '{3'b111, 1'b1, {1'b0, 1'b0, MODE_MANUAL, 1'b0}},
      '{3'b101, 1'b0, '0},   // right press
      '{3'b111, 1'b0, '0},   // short release: right enter, no cycling
      '{3'b111, 1'b0, '0},   // enter skips its wait, relay forward
      '{3'b011, 1'b0, '0},   // forced panic keeps the relay this tick
      '{3'b111, 1'b0, '0},
      '{3'b011, 1'b1, {1'b0, 1'b0, MODE_MANUAL, 1'b0}},
      '{3'b111, 1'b0, '0},
      '{3'b110, 1'b0, '0},   // left held for three ticks
      '{3'b110, 1'b0, '0},
      '{3'b110, 1'b0, '0},
      '{3'b111, 1'b0, '0},   // long release: left enter with cycling
      '{3'b111, 1'b0, '0},
      '{3'b111, 1'b0, '0},
      '{3'b110, 1'b0, '0},
      '{3'b111, 1'b0, '0},   // release during update: left exit
      '{3'b111, 1'b0, '0},
      '{3'b111, 1'b0, '0},   // exit wait over: reverse to right enter
      '{3'b011, 1'b0, '0},
      '{3'b011, 1'b0, '0},
      '{3'b111, 1'b0, '0},
      '{3'b011, 1'b0, '0},
      '{3'b100, 1'b0, '0},   // right and left together
      '{3'b111, 1'b0, '0},   // both released at once: right wins
      '{3'b111, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      collect_results();
    join_none

    c = '{enter_delay_ms: 16'd2, exit_delay_ms: 16'd2, long_press_ms: 16'd2,
          panic_timeout_ms: 16'd4, debounce_ms: 8'd0};
    program_regs(c);
    for (int k = 0; k < NumSteps; k++) send_tick(steps[k].stim, steps[k].typed, steps[k].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: c = '0;
        4: c = '{enter_delay_ms: 16'hFFFF, exit_delay_ms: 16'hFFFF, long_press_ms: 16'hFFFF,
                 panic_timeout_ms: 16'hFFFF, debounce_ms: 8'hFF};
        default: begin
          c.enter_delay_ms = 16'($urandom_range(0, 20));
          c.exit_delay_ms = 16'($urandom_range(0, 20));
          c.long_press_ms = 16'($urandom_range(0, 25));
          c.panic_timeout_ms = 16'($urandom_range(3, 60));
          c.debounce_ms = 8'($urandom_range(1, 4));
        end
      endcase
      // The sender holds off here until every result is back.
      wait_drained();
      program_regs(c);
      phase_ticks = 0;
      while (phase_ticks < PhaseTicks) play_gesture();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: timed_bidirectional_relay_sequencer.f
sv/trbs_pkg.sv
sv/trbs_button.sv
sv/trbs_seq.sv
sv/timed_bidirectional_relay_sequencer.sv
sv/trbs_checker.sv
test/testbench.sv
